// ----- rtl/lcdns_pkg.sv -----
// ============================================================================
// LCD nibble sequencer package
// Shared types, codes and constants for the 4-bit character display driver.
// ============================================================================
package lcdns_pkg;

    // Display geometry.
    localparam int COLUMNS = 20;
    localparam int LINES   = 4;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Command codes on the op field.
    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_SET_CURSOR = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_HOME       = 3'd3;
    localparam logic [2:0] OP_INIT       = 3'd4;

    // Configuration register indexes.
    localparam logic [7:0] REG_LINE1_BASE = 8'd0;
    localparam logic [7:0] REG_LINE2_BASE = 8'd1;
    localparam logic [7:0] REG_LINE3_BASE = 8'd2;
    localparam logic [7:0] REG_LINE4_BASE = 8'd3;

    // Reset values of the line base addresses.
    localparam logic [6:0] LINE1_BASE_RST = 7'h00;
    localparam logic [6:0] LINE2_BASE_RST = 7'h40;
    localparam logic [6:0] LINE3_BASE_RST = 7'h14;
    localparam logic [6:0] LINE4_BASE_RST = 7'h54;

    // Display controller command bytes.
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;

    // Step indexes inside a sequence.
    localparam logic [3:0] LAST_SINGLE = 4'd0;
    localparam logic [3:0] LAST_BYTE   = 4'd1;
    localparam logic [3:0] LAST_TWO    = 4'd3;
    localparam logic [3:0] LAST_INIT   = 4'd10;

    // Kind of work handed from the front part to the back part.
    typedef enum logic [1:0] {
        K_PUT  = 2'd0,  // data byte, then an optional set-address byte
        K_CMD  = 2'd1,  // one command byte
        K_INIT = 2'd2,  // power-on initialisation sequence
        K_NOTE = 2'd3   // a single result without a transfer
    } kind_t;

    // One queued request.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] cmd_byte;
        logic [3:0] last_step;
        logic       status;
        logic [2:0] cursor_line;
        logic [5:0] cursor_column;
    } desc_t;

    // Queue status seen by both parts.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // One result towards the display.
    typedef struct packed {
        logic       transfer_valid;
        logic       reg_select;
        logic [3:0] nibble;
        logic       check_busy;
        logic       status;
        logic [2:0] cursor_line;
        logic [5:0] cursor_column;
        logic       last;
    } res_t;

    // Nibble and busy flag of one step of the initialisation sequence.
    typedef struct packed {
        logic [3:0] nibble;
        logic       busy;
    } init_nib_t;

    function automatic init_nib_t init_step(input logic [3:0] step);
        init_nib_t r;
        case (step)
            4'd0:    r = '{nibble: 4'h3, busy: 1'b0};
            4'd1:    r = '{nibble: 4'h2, busy: 1'b0};
            4'd2:    r = '{nibble: 4'h8, busy: 1'b0};
            4'd3:    r = '{nibble: 4'h2, busy: 1'b0};
            4'd4:    r = '{nibble: 4'h8, busy: 1'b0};
            4'd5:    r = '{nibble: 4'h0, busy: 1'b1};
            4'd6:    r = '{nibble: 4'hC, busy: 1'b0};
            4'd7:    r = '{nibble: 4'h0, busy: 1'b1};
            4'd8:    r = '{nibble: 4'h1, busy: 1'b0};
            4'd9:    r = '{nibble: 4'h0, busy: 1'b1};
            4'd10:   r = '{nibble: 4'h6, busy: 1'b0};
            default: r = '{nibble: 4'h0, busy: 1'b0};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/lcdns_queue.sv -----
// ============================================================================
// LCD nibble sequencer request queue
// Short first-word-fall-through queue between the front and back parts.
// ============================================================================
module lcdns_queue
    import lcdns_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  desc_t  push_desc,
    input  logic   pop,
    output desc_t  head,
    output qstat_t stat
);

    desc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    // Status and head of the queue.
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    // Storage, written only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/lcdns_front.sv -----
// ============================================================================
// LCD nibble sequencer front part
// Accepts commands, tracks the cursor, holds the line bases and builds
// the queued request for each command.
// ============================================================================
module lcdns_front
    import lcdns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [2:0] op,
    input  logic [7:0] char_code,
    input  logic [2:0] target_line,
    input  logic [5:0] target_column,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [6:0] cfg_data,
    input  qstat_t     qstat,
    output logic       push,
    output desc_t      push_desc
);

    logic [6:0] line_base_reg [4];
    logic [2:0] line_now_reg, line_now_next;
    logic [5:0] column_now_reg, column_now_next;

    logic [5:0] col_inc;
    logic       col_wrap;
    logic [2:0] line_inc;
    logic [2:0] line_wrapped;
    logic       target_ok;
    logic [2:0] sel_line;
    logic [5:0] sel_column;
    logic [1:0] base_idx;
    logic [6:0] address;

    assign cmd_ready = !qstat.full;
    assign cfg_ready = 1'b1;
    assign push      = cmd_valid && cmd_ready;

    // Cursor advance for put character, with line wrap.
    assign col_inc      = column_now_reg + 6'd1;
    assign col_wrap     = (col_inc > 6'(COLUMNS));
    assign line_inc     = line_now_reg + 3'd1;
    assign line_wrapped = (line_inc > 3'(LINES)) ? 3'd1 : line_inc;

    // Range check of a set cursor request.
    assign target_ok = (target_line >= 3'd1) && (target_line <= 3'(LINES)) &&
                       (target_column >= 6'd1) && (target_column <= 6'(COLUMNS));

    // One display address is needed per command: the wrapped position for
    // put character, the target position otherwise.
    assign sel_line   = (op == OP_PUT_CHAR) ? line_wrapped : target_line;
    assign sel_column = (op == OP_PUT_CHAR) ? 6'd1 : target_column;
    assign base_idx   = 2'(sel_line - 3'd1);
    assign address    = line_base_reg[base_idx] + 7'(sel_column) - 7'd1;

    // Request build and next cursor position.
    always_comb
    begin
        push_desc.kind          = K_NOTE;
        push_desc.data_byte     = char_code;
        push_desc.cmd_byte      = CMD_SET_ADDR | {1'b0, address};
        push_desc.last_step     = LAST_SINGLE;
        push_desc.status        = 1'b0;
        line_now_next           = line_now_reg;
        column_now_next         = column_now_reg;
        unique case (op)
            OP_PUT_CHAR:
            begin
                push_desc.kind = K_PUT;
                if (col_wrap)
                begin
                    push_desc.last_step = LAST_TWO;
                    line_now_next       = line_wrapped;
                    column_now_next     = 6'd1;
                end
                else
                begin
                    push_desc.last_step = LAST_BYTE;
                    column_now_next     = col_inc;
                end
            end
            OP_SET_CURSOR:
            begin
                if (target_ok)
                begin
                    push_desc.kind      = K_CMD;
                    push_desc.last_step = LAST_BYTE;
                    line_now_next       = target_line;
                    column_now_next     = target_column;
                end
                else
                begin
                    push_desc.status = 1'b1;
                end
            end
            OP_CLEAR, OP_HOME:
            begin
                push_desc.kind      = K_CMD;
                push_desc.cmd_byte  = (op == OP_CLEAR) ? CMD_CLEAR : CMD_HOME;
                push_desc.last_step = LAST_BYTE;
                line_now_next       = 3'd1;
                column_now_next     = 6'd1;
            end
            OP_INIT:
            begin
                push_desc.kind      = K_INIT;
                push_desc.last_step = LAST_INIT;
                line_now_next       = 3'd1;
                column_now_next     = 6'd1;
            end
            default:
            begin
                push_desc.kind = K_NOTE;
            end
        endcase
        push_desc.cursor_line   = line_now_next;
        push_desc.cursor_column = column_now_next;
    end

    // Cursor state and line base registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_now_reg     <= 3'd1;
            column_now_reg   <= 6'd1;
            line_base_reg[0] <= LINE1_BASE_RST;
            line_base_reg[1] <= LINE2_BASE_RST;
            line_base_reg[2] <= LINE3_BASE_RST;
            line_base_reg[3] <= LINE4_BASE_RST;
        end
        else
        begin
            if (push)
            begin
                line_now_reg   <= line_now_next;
                column_now_reg <= column_now_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LINE1_BASE: line_base_reg[0] <= cfg_data;
                    REG_LINE2_BASE: line_base_reg[1] <= cfg_data;
                    REG_LINE3_BASE: line_base_reg[2] <= cfg_data;
                    REG_LINE4_BASE: line_base_reg[3] <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/lcdns_back.sv -----
// ============================================================================
// LCD nibble sequencer back part
// Walks the request at the head of the queue, one nibble result a cycle while
// the output is not stalled, into the output register.
// ============================================================================
module lcdns_back
    import lcdns_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  desc_t  head,
    input  qstat_t qstat,
    output logic   pop,
    output logic   res_valid,
    input  logic   res_ready,
    output res_t   res
);

    logic       res_valid_reg;
    res_t       res_reg, res_next;
    logic [3:0] step_reg;
    logic       load_en;
    logic       step_last;
    logic [7:0] cur_byte;
    init_nib_t  init_nib;

    assign load_en   = !res_valid_reg || res_ready;
    assign step_last = (step_reg == head.last_step);
    assign pop       = load_en && !qstat.empty && step_last;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Byte of the current step: data for the first pair of a put character.
    assign cur_byte = ((head.kind == K_PUT) && !step_reg[1]) ? head.data_byte : head.cmd_byte;
    assign init_nib = init_step(step_reg);

    // Result of the current step.
    always_comb
    begin
        res_next.transfer_valid = 1'b1;
        res_next.reg_select     = 1'b0;
        res_next.nibble         = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        res_next.check_busy     = !step_reg[0];
        res_next.status         = 1'b0;
        unique case (head.kind)
            K_PUT:
            begin
                res_next.reg_select = !step_reg[1];
            end
            K_CMD:
            begin
                res_next.reg_select = 1'b0;
            end
            K_INIT:
            begin
                res_next.nibble     = init_nib.nibble;
                res_next.check_busy = init_nib.busy;
            end
            K_NOTE:
            begin
                res_next.transfer_valid = 1'b0;
                res_next.nibble         = 4'h0;
                res_next.check_busy     = 1'b0;
                res_next.status         = head.status;
            end
            default:
            begin
                res_next.transfer_valid = 1'b0;
            end
        endcase
        res_next.cursor_line   = head.cursor_line;
        res_next.cursor_column = head.cursor_column;
        res_next.last          = step_last;
    end

    // Step counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else if (load_en)
        begin
            res_valid_reg <= !qstat.empty;
            if (!qstat.empty)
            begin
                step_reg <= step_last ? 4'd0 : step_reg + 4'd1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load_en && !qstat.empty)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- rtl/char_lcd_nibble_sequencer.sv -----
// ============================================================================
// Character LCD nibble sequencer
// Turns display commands into 4-bit nibble transfers and tracks the cursor.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------------
//  command   cmd_valid / cmd_ready  op, char_code, target_line, target_column
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//  result    res_valid / res_ready  transfer_valid, reg_select, nibble,
//                                   check_busy, status, cursor_line,
//                                   cursor_column, last
//
//  A command is accepted and queued; the back part issues one result per
//  cycle while the result side takes them, and a command gives 1 result
//  (rejected or unknown), 2 (one byte), 4 (put character with wrap) or
//  11 (init). The result register sets that rate.
//  Reset sets the cursor to line 1, column 1 and loads the default line bases.
//  A stalled result holds the back part; commands are still taken until the
//  two-entry queue is full. Configuration writes are always taken.
//
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [2:0] op,
    input  logic [7:0] char_code,
    input  logic [2:0] target_line,
    input  logic [5:0] target_column,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [6:0] cfg_data,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       transfer_valid,
    output logic       reg_select,
    output logic [3:0] nibble,
    output logic       check_busy,
    output logic       status,
    output logic [2:0] cursor_line,
    output logic [5:0] cursor_column,
    output logic       last
);

    qstat_t qstat;
    desc_t  push_desc;
    desc_t  head;
    logic   push;
    logic   pop;
    res_t   res;

    // Front part: command intake and cursor tracking.
    lcdns_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .op            (op),
        .char_code     (char_code),
        .target_line   (target_line),
        .target_column (target_column),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .qstat         (qstat),
        .push          (push),
        .push_desc     (push_desc)
    );

    // Queue between the two parts.
    lcdns_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    // Back part: nibble sequencing.
    lcdns_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign transfer_valid = res.transfer_valid;
    assign reg_select     = res.reg_select;
    assign nibble         = res.nibble;
    assign check_busy     = res.check_busy;
    assign status         = res.status;
    assign cursor_line    = res.cursor_line;
    assign cursor_column  = res.cursor_column;
    assign last           = res.last;

    // A failure result never carries a transfer and closes its command.
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status |-> !transfer_valid && last)
        else $error("failure result carries a transfer or is not last");

    // A busy poll is only requested ahead of a real transfer.
    a_busy_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && check_busy |-> transfer_valid)
        else $error("busy poll flagged without a transfer");

    // The tracked cursor always lies on the display.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cursor_line >= 3'd1) && (cursor_line <= 3'(LINES)) &&
                      (cursor_column >= 6'd1) && (cursor_column <= 6'(COLUMNS)))
        else $error("cursor position off the display");

endmodule

// ----- sim/char_lcd_nibble_sequencer_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Character LCD nibble sequencer testbench
// Drives display commands and line base writes through their handshakes,
// predicts every nibble transfer and cursor report, and checks each result
// request in order while both sides pause at random.
// ============================================================================
module char_lcd_nibble_sequencer_test;
    import lcdns_pkg::*;

    // Op codes the block does not know; each gives one empty result.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Register index beyond the line bases; writes there are dropped.
    localparam logic [7:0] REG_TOP = 8'hFF;

    // Initialisation bytes besides clear.
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

    localparam int PHASES     = 5;
    localparam int PHASE_CMDS = 70;
    localparam int DRAIN_MAX  = 5000;

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       cmd_valid     = 1'b0;
    logic       cmd_ready;
    logic [2:0] op            = '0;
    logic [7:0] char_code     = '0;
    logic [2:0] target_line   = '0;
    logic [5:0] target_column = '0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index     = '0;
    logic [6:0] cfg_data      = '0;
    logic       res_valid;
    logic       res_ready     = 1'b0;
    logic       transfer_valid;
    logic       reg_select;
    logic [3:0] nibble;
    logic       check_busy;
    logic       status;
    logic [2:0] cursor_line;
    logic [5:0] cursor_column;
    logic       last;

    // Travels with each command: a hand-written result replaces the prediction.
    logic       fixed_answer  = 1'b0;
    res_t       fixed_result  = '0;

    // Predicted display state and the results still owed by the block.
    logic [6:0] line_base [4] = '{LINE1_BASE_RST, LINE2_BASE_RST,
                                  LINE3_BASE_RST, LINE4_BASE_RST};
    logic [2:0] pred_line     = 3'd1;
    logic [5:0] pred_column   = 6'd1;
    res_t       results_due [$];
    res_t       staged [$];

    int         mismatches     = 0;
    int         commands_sent  = 0;
    int         commands_taken = 0;
    bit         calm           = 1'b0;
    int         stall_left     = 0;

    // One directed command, with its single result where that is plain.
    typedef struct {
        logic [2:0] op;
        logic [7:0] ch;
        logic [2:0] tl;
        logic [5:0] tc;
        bit         fixed;
        logic       status;
        logic [2:0] line;
        logic [5:0] column;
    } step_t;

    step_t directed_steps [$];

    char_lcd_nibble_sequencer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .op             (op),
        .char_code      (char_code),
        .target_line    (target_line),
        .target_column  (target_column),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .transfer_valid (transfer_valid),
        .reg_select     (reg_select),
        .nibble         (nibble),
        .check_busy     (check_busy),
        .status         (status),
        .cursor_line    (cursor_line),
        .cursor_column  (cursor_column),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hang anywhere in the run.
    initial
    begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

    // Pause length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Display RAM address of a cursor position, wrapped to seven bits.
    function automatic logic [6:0] ram_address(input logic [2:0] ln, input logic [5:0] cl);
        int idx;
        int addr;
        idx  = (int'(ln) - 1) & 3;
        addr = int'(line_base[idx]) + int'(cl) - 1;
        return addr[6:0];
    endfunction

    task automatic stage_nibble(input logic tv, input logic rs, input logic [3:0] nib,
                                input logic busy, input logic st);
        res_t r;
        r                = '0;
        r.transfer_valid = tv;
        r.reg_select     = rs;
        r.nibble         = nib;
        r.check_busy     = busy;
        r.status         = st;
        staged.push_back(r);
    endtask

    task automatic stage_byte(input logic rs, input logic [7:0] data, input logic busy);
        stage_nibble(1'b1, rs, data[7:4], busy, 1'b0);
        stage_nibble(1'b1, rs, data[3:0], 1'b0, 1'b0);
    endtask

    // Works out the results of one accepted command and moves the cursor.
    task automatic sequence_command(input logic [2:0] c_op, input logic [7:0] c_char,
                                    input logic [2:0] c_line, input logic [5:0] c_col);
        res_t r;
        staged.delete();
        case (c_op)
            OP_PUT_CHAR:
            begin
                stage_byte(1'b1, c_char, 1'b1);
                pred_column = pred_column + 6'd1;
                if (pred_column > COLUMNS)
                begin
                    pred_column = 6'd1;
                    pred_line   = (pred_line >= LINES) ? 3'd1 : pred_line + 3'd1;
                    stage_byte(1'b0, CMD_SET_ADDR | {1'b0, ram_address(pred_line, pred_column)},
                               1'b1);
                end
            end
            OP_SET_CURSOR:
            begin
                if (c_line < 1 || c_line > LINES || c_col < 1 || c_col > COLUMNS)
                    stage_nibble(1'b0, 1'b0, 4'h0, 1'b0, 1'b1);
                else
                begin
                    stage_byte(1'b0, CMD_SET_ADDR | {1'b0, ram_address(c_line, c_col)}, 1'b1);
                    pred_line   = c_line;
                    pred_column = c_col;
                end
            end
            OP_CLEAR, OP_HOME:
            begin
                stage_byte(1'b0, (c_op == OP_CLEAR) ? CMD_CLEAR : CMD_HOME, 1'b1);
                pred_line   = 3'd1;
                pred_column = 6'd1;
            end
            OP_INIT:
            begin
                stage_nibble(1'b1, 1'b0, NIB_WAKE, 1'b0, 1'b0);
                stage_byte(1'b0, CMD_FUNC_4BIT, 1'b0);
                stage_byte(1'b0, CMD_FUNC_4BIT, 1'b0);
                stage_byte(1'b0, CMD_DISPLAY_ON, 1'b1);
                stage_byte(1'b0, CMD_CLEAR, 1'b1);
                stage_byte(1'b0, CMD_ENTRY_MODE, 1'b1);
                pred_line   = 3'd1;
                pred_column = 6'd1;
            end
            default:
                stage_nibble(1'b0, 1'b0, 4'h0, 1'b0, 1'b0);
        endcase
        // Every result reports the cursor after the whole command.
        for (int i = 0; i < staged.size(); i++)
        begin
            r               = staged[i];
            r.cursor_line   = pred_line;
            r.cursor_column = pred_column;
            r.last          = (i == staged.size() - 1);
            results_due.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: random stalls, with calm stretches where it always takes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                res_ready  <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Follows every request on all three channels in a single process.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready && cfg_index < 8'd4)
                line_base[cfg_index[1:0]] = cfg_data;

            if (cmd_valid && cmd_ready)
            begin
                commands_taken++;
                if (fixed_answer)
                    results_due.push_back(fixed_result);
                else
                    sequence_command(op, char_code, target_line, target_column);
            end

            if (res_valid && res_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual nibble %0h last %0b",
                             $time, nibble, last);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("transfer_valid", want.transfer_valid, transfer_valid);
                    check_field("reg_select", want.reg_select, reg_select);
                    check_field("nibble", want.nibble, nibble);
                    check_field("check_busy", want.check_busy, check_busy);
                    check_field("status", want.status, status);
                    check_field("cursor_line", want.cursor_line, cursor_line);
                    check_field("cursor_column", want.cursor_column, cursor_column);
                    check_field("last", want.last, last);
                end
            end
        end
    end

    // Offers one command after a random pause and waits until it is taken.
    task automatic send_command(input logic [2:0] c_op, input logic [7:0] c_char,
                                input logic [2:0] c_line, input logic [5:0] c_col,
                                input bit fixed, input res_t fixed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        op            <= c_op;
        char_code     <= c_char;
        target_line   <= c_line;
        target_column <= c_col;
        fixed_answer  <= fixed;
        fixed_result  <= fixed_res;
        commands_sent++;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // Waits for every owed result, then for the queue to settle.
    task automatic wait_drained();
        int n;
        n = 0;
        @(posedge clk);
        while ((results_due.size() != 0 || commands_taken != commands_sent) && n < DRAIN_MAX)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Loads all four line bases, after as many writes to unused indexes as junk asks for.
    task automatic load_bases(input logic [6:0] b1, input logic [6:0] b2,
                              input logic [6:0] b3, input logic [6:0] b4,
                              input int junk);
        for (int i = 0; i < junk; i++)
            write_reg((i == 0) ? REG_TOP : 8'($urandom_range(4, 255)), 7'($urandom));
        write_reg(REG_LINE1_BASE, b1);
        write_reg(REG_LINE2_BASE, b2);
        write_reg(REG_LINE3_BASE, b3);
        write_reg(REG_LINE4_BASE, b4);
        cfg_valid <= 1'b0;
    endtask

    task automatic plan(input logic [2:0] p_op, input logic [7:0] p_ch,
                        input logic [2:0] p_tl, input logic [5:0] p_tc);
        step_t s;
        s = '{p_op, p_ch, p_tl, p_tc, 1'b0, 1'b0, 3'd0, 6'd0};
        directed_steps.push_back(s);
    endtask

    task automatic plan_fixed(input logic [2:0] p_op, input logic [2:0] p_tl,
                              input logic [5:0] p_tc, input logic p_status,
                              input logic [2:0] p_line, input logic [5:0] p_col);
        step_t s;
        s = '{p_op, 8'($urandom), p_tl, p_tc, 1'b1, p_status, p_line, p_col};
        directed_steps.push_back(s);
    endtask

    // One random command, weighted towards character runs that wrap lines.
    task automatic send_random_command();
        int         r;
        logic [2:0] c_op;
        logic [7:0] c_char;
        logic [2:0] c_line;
        logic [5:0] c_col;
        r      = $urandom_range(0, 99);
        c_char = 8'($urandom);
        c_line = 3'($urandom);
        c_col  = 6'($urandom);
        if (r < 55)
            c_op = OP_PUT_CHAR;
        else if (r < 75)
        begin
            c_op = OP_SET_CURSOR;
            if ($urandom_range(0, 4) != 0)
            begin
                c_line = 3'($urandom_range(1, LINES));
                c_col  = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(15, COLUMNS))
                                                     : 6'($urandom_range(1, COLUMNS));
            end
        end
        else if (r < 83)
            c_op = OP_CLEAR;
        else if (r < 90)
            c_op = OP_HOME;
        else if (r < 94)
            c_op = OP_INIT;
        else
            c_op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        send_command(c_op, c_char, c_line, c_col, 1'b0, '0);
    endtask

    initial
    begin
        res_t  fr;
        step_t s;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands from reset defaults; cursor moves are noted per row.
        plan_fixed(OP_SET_CURSOR, 3'd0, 6'd1, 1'b1, 3'd1, 6'd1);
        plan_fixed(OP_SPARE_5, 3'd7, 6'd63, 1'b0, 3'd1, 6'd1);
        plan(OP_INIT, 8'h00, 3'd0, 6'd0);
        plan(OP_PUT_CHAR, 8'hFF, 3'd7, 6'd63);
        plan(OP_PUT_CHAR, 8'h00, 3'd0, 6'd0);
        plan(OP_SET_CURSOR, 8'h00, 3'd4, 6'd20);
        plan(OP_PUT_CHAR, 8'hA5, 3'd0, 6'd0);     // wraps the last line to line 1
        plan(OP_SET_CURSOR, 8'h00, 3'd3, 6'd20);
        plan(OP_PUT_CHAR, 8'h5A, 3'd0, 6'd0);     // wraps line 3 to line 4
        plan_fixed(OP_SET_CURSOR, 3'd5, 6'd1, 1'b1, 3'd4, 6'd1);
        plan_fixed(OP_SET_CURSOR, 3'd7, 6'd63, 1'b1, 3'd4, 6'd1);
        plan_fixed(OP_SET_CURSOR, 3'd1, 6'd21, 1'b1, 3'd4, 6'd1);
        plan_fixed(OP_SET_CURSOR, 3'd2, 6'd0, 1'b1, 3'd4, 6'd1);
        plan_fixed(OP_SPARE_6, 3'd0, 6'd0, 1'b0, 3'd4, 6'd1);
        plan_fixed(OP_SPARE_7, 3'd7, 6'd63, 1'b0, 3'd4, 6'd1);
        plan(OP_SET_CURSOR, 8'h00, 3'd1, 6'd20);
        plan(OP_PUT_CHAR, 8'h80, 3'd0, 6'd0);     // wraps line 1 to line 2
        plan(OP_CLEAR, 8'h00, 3'd0, 6'd0);
        plan(OP_SET_CURSOR, 8'h00, 3'd2, 6'd1);
        plan(OP_HOME, 8'h00, 3'd0, 6'd0);
        plan(OP_PUT_CHAR, 8'h7F, 3'd0, 6'd0);

        foreach (directed_steps[i])
        begin
            s                 = directed_steps[i];
            fr                = '0;
            fr.status         = s.status;
            fr.cursor_line    = s.line;
            fr.cursor_column  = s.column;
            fr.last           = 1'b1;
            send_command(s.op, s.ch, s.tl, s.tc, s.fixed, fr);
        end

        // Random phases, each under its own set of line bases.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                cmd_valid <= 1'b0;
                wait_drained();
                case (phase)
                    1: load_bases(7'h00, 7'h00, 7'h00, 7'h00, 1);
                    2: load_bases(7'h7F, 7'h7F, 7'h7F, 7'h7F, 0);
                    3: load_bases(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 3);
                    default: load_bases(7'h7F, 7'h00, 7'($urandom), 7'($urandom), 2);
                endcase
            end
            calm = (phase == 2);
            repeat (PHASE_CMDS) send_random_command();
        end
        cmd_valid <= 1'b0;
        wait_drained();

        while (results_due.size() != 0)
        begin
            fr = results_due.pop_front();
            $display("%0t: result never arrived, expected nibble %0h last %0b, actual none",
                     $time, fr.nibble, fr.last);
            mismatches++;
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
